/* rtl/ibc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibc_pkg
// Shared constants for the index box coalesce test block.
// ----------------------------------------------------------------------------
package ibc_pkg;

    localparam int NUM_DIMS        = 3;
    localparam int MAX_DIMS        = 3;
    localparam int COORD_WIDTH_DEF = 32;

    localparam int DIMS_W = 2;
    localparam logic [DIMS_W-1:0] DIMS_RESET = 2'd3;

    localparam int NUM_IN_FIELDS  = 4 * NUM_DIMS;
    localparam int NUM_OUT_FIELDS = 2 * NUM_DIMS;

    // field slots inside the request word, lowest first
    localparam int SLOT_A_LO = 0;
    localparam int SLOT_A_HI = NUM_DIMS;
    localparam int SLOT_B_LO = 2 * NUM_DIMS;
    localparam int SLOT_B_HI = 3 * NUM_DIMS;

    localparam int SLOT_OUT_LO = 0;
    localparam int SLOT_OUT_HI = NUM_DIMS;

    typedef struct packed {
        logic merged;
    } t_result_flags;

endpackage

/* rtl/ibc_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibc_core
// Combinational coalesce decision and bounding union for one box pair.
// ----------------------------------------------------------------------------
module ibc_core #(
    parameter int COORD_WIDTH = ibc_pkg::COORD_WIDTH_DEF
) (
    input  logic [ibc_pkg::DIMS_W-1:0]                     i_dims,
    input  logic [ibc_pkg::NUM_DIMS-1:0][COORD_WIDTH-1:0]  i_a_lo,
    input  logic [ibc_pkg::NUM_DIMS-1:0][COORD_WIDTH-1:0]  i_a_hi,
    input  logic [ibc_pkg::NUM_DIMS-1:0][COORD_WIDTH-1:0]  i_b_lo,
    input  logic [ibc_pkg::NUM_DIMS-1:0][COORD_WIDTH-1:0]  i_b_hi,
    output ibc_pkg::t_result_flags                         o_flags,
    output logic [ibc_pkg::NUM_DIMS-1:0][COORD_WIDTH-1:0]  o_lo,
    output logic [ibc_pkg::NUM_DIMS-1:0][COORD_WIDTH-1:0]  o_hi
);
    import ibc_pkg::*;

    localparam logic [DIMS_W-1:0] MAX_D = DIMS_W'(MAX_DIMS);

    logic [DIMS_W-1:0]   dims_eff;
    logic [NUM_DIMS-1:0] used;
    logic [NUM_DIMS-1:0] a_empty_d;
    logic [NUM_DIMS-1:0] b_empty_d;
    logic [NUM_DIMS-1:0] eq_d;
    logic [NUM_DIMS-1:0] join_d;
    logic [NUM_DIMS-1:0] a_has_b_d;
    logic [NUM_DIMS-1:0] b_has_a_d;
    logic [NUM_DIMS-1:0] slide_k;
    logic                a_empty;
    logic                b_empty;
    logic                ok;

    assign dims_eff = (i_dims > MAX_D) ? MAX_D : i_dims;

    always_comb begin
        logic signed [COORD_WIDTH-1:0] alo, ahi, blo, bhi;
        logic signed [COORD_WIDTH:0]   ahi_p1, bhi_p1, alo_x, blo_x;
        for (int i = 0; i < NUM_DIMS; i++) begin
            alo    = signed'(i_a_lo[i]);
            ahi    = signed'(i_a_hi[i]);
            blo    = signed'(i_b_lo[i]);
            bhi    = signed'(i_b_hi[i]);
            ahi_p1 = (COORD_WIDTH+1)'(ahi) + (COORD_WIDTH+1)'(1);
            bhi_p1 = (COORD_WIDTH+1)'(bhi) + (COORD_WIDTH+1)'(1);
            alo_x  = (COORD_WIDTH+1)'(alo);
            blo_x  = (COORD_WIDTH+1)'(blo);
            used[i]      = DIMS_W'(i) < dims_eff;
            a_empty_d[i] = used[i] && (ahi < alo);
            b_empty_d[i] = used[i] && (bhi < blo);
            eq_d[i]      = !used[i] || ((alo == blo) && (ahi == bhi));
            join_d[i]    = ((blo_x <= ahi_p1) && (ahi <= bhi))
                        || ((blo <= alo) && (alo_x <= bhi_p1));
            a_has_b_d[i] = !used[i] || ((alo <= blo) && (ahi >= bhi));
            b_has_a_d[i] = !used[i] || ((blo <= alo) && (bhi >= ahi));
        end
    end

    always_comb begin
        logic others;
        for (int k = 0; k < NUM_DIMS; k++) begin
            others = 1'b1;
            for (int i = 0; i < NUM_DIMS; i++) begin
                if (i != k && !eq_d[i]) begin
                    others = 1'b0;
                end
            end
            slide_k[k] = used[k] && others && join_d[k];
        end
    end

    assign a_empty = |a_empty_d;
    assign b_empty = |b_empty_d;
    assign ok      = a_empty || b_empty || (|slide_k) || (&a_has_b_d) || (&b_has_a_d);

    always_comb begin
        for (int i = 0; i < NUM_DIMS; i++) begin
            o_lo[i] = i_a_lo[i];
            o_hi[i] = i_a_hi[i];
            if (ok && !b_empty && used[i]) begin
                if (a_empty) begin
                    o_lo[i] = i_b_lo[i];
                    o_hi[i] = i_b_hi[i];
                end else begin
                    o_lo[i] = (signed'(i_a_lo[i]) < signed'(i_b_lo[i])) ? i_a_lo[i] : i_b_lo[i];
                    o_hi[i] = (signed'(i_a_hi[i]) > signed'(i_b_hi[i])) ? i_a_hi[i] : i_b_hi[i];
                end
            end
        end
    end

    assign o_flags.merged = ok;

endmodule

/* rtl/index_box_coalesce_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// index_box_coalesce_test
// Decides whether the union of two index boxes is a box and forms it.
//
//  channel  | dir | payload
//  ---------+-----+--------------------------------------------------------
//  s        | in  | tdata: a_lo0..2, a_hi0..2, b_lo0..2, b_hi0..2
//  m        | out | tdata: out_lo0..2, out_hi0..2; tuser: merged
//  cfg      | in  | wdata: dims_in_use
//
//  One request per cycle sustained while the result side is not stalled; a
//  result passes the input register, then the result register, before it
//  leaves with o_m_tvalid.
//  A stalled result holds in the result register while the input register
//  still takes one more request; o_s_tready drops only when both are full.
//  Synchronous active-low reset clears valids and sets dims_in_use to 3.
// ----------------------------------------------------------------------------
module index_box_coalesce_test #(
    parameter int COORD_WIDTH = ibc_pkg::COORD_WIDTH_DEF,
    localparam int IN_W  = ((ibc_pkg::NUM_IN_FIELDS * COORD_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((ibc_pkg::NUM_OUT_FIELDS * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [ibc_pkg::DIMS_W-1:0]  i_cfg_wdata,  // dims_in_use
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // a_lo0, a_lo1, a_lo2, a_hi0, a_hi1, a_hi2, b_lo0, b_lo1, b_lo2, b_hi0, b_hi1, b_hi2
    input  logic [IN_W-1:0]             i_s_tdata,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // out_lo0, out_lo1, out_lo2, out_hi0, out_hi1, out_hi2
    output logic [OUT_W-1:0]            o_m_tdata,
    // merged
    output logic [0:0]                  o_m_tuser
);
    import ibc_pkg::*;

    localparam int IN_BITS  = NUM_IN_FIELDS * COORD_WIDTH;
    localparam int OUT_BITS = NUM_OUT_FIELDS * COORD_WIDTH;

    logic [DIMS_W-1:0]   r_dims;
    logic                r_in_valid;
    logic [IN_BITS-1:0]  r_in_data;
    logic                r_out_valid;
    logic [OUT_BITS-1:0] r_out_data;
    t_result_flags       r_out_flags;

    logic                                  adv;
    logic [NUM_DIMS-1:0][COORD_WIDTH-1:0]  a_lo, a_hi, b_lo, b_hi;
    logic [NUM_DIMS-1:0][COORD_WIDTH-1:0]  res_lo, res_hi;
    t_result_flags                         res_flags;
    logic [OUT_BITS-1:0]                   n_out_data;

    assign adv        = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || adv;

    always_comb begin
        for (int i = 0; i < NUM_DIMS; i++) begin
            a_lo[i] = r_in_data[(SLOT_A_LO + i) * COORD_WIDTH +: COORD_WIDTH];
            a_hi[i] = r_in_data[(SLOT_A_HI + i) * COORD_WIDTH +: COORD_WIDTH];
            b_lo[i] = r_in_data[(SLOT_B_LO + i) * COORD_WIDTH +: COORD_WIDTH];
            b_hi[i] = r_in_data[(SLOT_B_HI + i) * COORD_WIDTH +: COORD_WIDTH];
        end
    end

    ibc_core #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_core (
        .i_dims  (r_dims),
        .i_a_lo  (a_lo),
        .i_a_hi  (a_hi),
        .i_b_lo  (b_lo),
        .i_b_hi  (b_hi),
        .o_flags (res_flags),
        .o_lo    (res_lo),
        .o_hi    (res_hi)
    );

    always_comb begin
        n_out_data = '0;
        for (int i = 0; i < NUM_DIMS; i++) begin
            n_out_data[(SLOT_OUT_LO + i) * COORD_WIDTH +: COORD_WIDTH] = res_lo[i];
            n_out_data[(SLOT_OUT_HI + i) * COORD_WIDTH +: COORD_WIDTH] = res_hi[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims      <= DIMS_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_dims <= i_cfg_wdata;
            end
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_data <= i_s_tdata[IN_BITS-1:0];
        end
        if (adv && r_in_valid) begin
            r_out_data  <= n_out_data;
            r_out_flags <= res_flags;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_W'(r_out_data);
    assign o_m_tuser  = r_out_flags.merged;

endmodule

/* rtl/ibc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibc_checker
// Port-level checks for index_box_coalesce_test, bound to the top level.
// ----------------------------------------------------------------------------
module ibc_checker #(
    parameter int COORD_WIDTH = ibc_pkg::COORD_WIDTH_DEF,
    localparam int OUT_W = ((ibc_pkg::NUM_OUT_FIELDS * COORD_WIDTH + 7) / 8) * 8
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_s_tvalid,
    input logic             o_s_tready,
    input logic             o_m_tvalid,
    input logic             i_m_tready,
    input logic [OUT_W-1:0] o_m_tdata,
    input logic [0:0]       o_m_tuser
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // input side backs up only behind a stalled result
    a_bp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid && !i_m_tready)
        else $error("ready low without output stall");

    // an accepted request shows a result valid once past the input and result registers
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |-> ##2 o_m_tvalid)
        else $error("accepted request produced no output valid");

    // nothing comes out right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

endmodule

bind index_box_coalesce_test ibc_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_ibc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

/* tb/index_box_coalesce_test_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// index_box_coalesce_test_test
// Self-checking bench for the index box coalesce test block.
//
// Box pairs are streamed in with random gaps, and results are taken out with
// random backpressure. A directed table covers empty boxes, touching and
// gapped intervals, containment, the coordinate extremes and every setting
// of dims_in_use. Random pairs follow, mostly built from one box with one
// dimension moved or with the box grown or shrunk, so that the merge rules
// are reached often. Each result is compared field by field against a
// behavioral predictor, or against a hand-written value where one is given.
// ----------------------------------------------------------------------------
module index_box_coalesce_test_test;

    localparam int CW           = ibc_pkg::COORD_WIDTH_DEF;
    localparam int ND           = ibc_pkg::NUM_DIMS;
    localparam int DRAIN_CYCLES = 4;
    localparam int TAIL_CYCLES  = 8;
    localparam int PHASE_ITEMS  = 250;
    localparam int CYCLE_LIMIT  = 1_000_000;

    typedef logic signed [CW-1:0] t_coord;
    typedef logic [ibc_pkg::DIMS_W-1:0] t_dims;

    // field order matches the stream words, lowest bits last in the list
    typedef struct packed {
        t_coord [ND-1:0] b_hi;
        t_coord [ND-1:0] b_lo;
        t_coord [ND-1:0] a_hi;
        t_coord [ND-1:0] a_lo;
    } t_box_pair;

    typedef struct packed {
        t_coord [ND-1:0] hi;
        t_coord [ND-1:0] lo;
    } t_box;

    typedef struct packed {
        logic merged;
        t_box box;
    } t_coalesce;

    typedef struct packed {
        t_dims     dims;
        logic      known;
        t_box_pair pair;
        t_coalesce want;
    } t_probe;

    localparam t_coord C_MIN = t_coord'(32'h8000_0000);
    localparam t_coord C_MAX = t_coord'(32'h7fff_ffff);

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    t_dims                 i_cfg_wdata;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [$bits(t_box_pair)-1:0] i_s_tdata;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [$bits(t_box)-1:0] o_m_tdata;
    logic [0:0]            o_m_tuser;

    t_coalesce union_q[$];
    t_probe    probes[$];
    t_dims     cur_dims = ibc_pkg::DIMS_RESET;
    int        fault_count = 0;
    int        cycles = 0;
    int        stall_left = 0;
    bit        tx_steady = 1'b0;
    bit        rx_steady = 1'b0;

    index_box_coalesce_test dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_coalesce predict_union(input t_box_pair p, input t_dims ndims);
        longint    alo[ND];
        longint    ahi[ND];
        longint    blo[ND];
        longint    bhi[ND];
        int        d;
        bit        a_empty;
        bit        b_empty;
        bit        ok;
        bit        others;
        bit        a_has_b;
        bit        b_has_a;
        t_coalesce r;
        d = (ndims > ibc_pkg::MAX_DIMS) ? ibc_pkg::MAX_DIMS : int'(ndims);
        a_empty = 1'b0;
        b_empty = 1'b0;
        ok = 1'b0;
        for (int i = 0; i < ND; i++) begin
            alo[i] = longint'($signed(p.a_lo[i]));
            ahi[i] = longint'($signed(p.a_hi[i]));
            blo[i] = longint'($signed(p.b_lo[i]));
            bhi[i] = longint'($signed(p.b_hi[i]));
            r.box.lo[i] = p.a_lo[i];
            r.box.hi[i] = p.a_hi[i];
        end
        for (int i = 0; i < d; i++) begin
            if (ahi[i] < alo[i]) a_empty = 1'b1;
            if (bhi[i] < blo[i]) b_empty = 1'b1;
        end
        if (a_empty || b_empty) begin
            ok = 1'b1;
        end else begin
            for (int k = 0; k < d; k++) begin
                others = 1'b1;
                for (int i = 0; i < d; i++) begin
                    if (i != k && !(alo[i] == blo[i] && ahi[i] == bhi[i])) others = 1'b0;
                end
                if (others && ((blo[k] <= ahi[k] + 1 && ahi[k] <= bhi[k]) ||
                               (blo[k] <= alo[k] && alo[k] <= bhi[k] + 1))) ok = 1'b1;
            end
            if (!ok) begin
                a_has_b = 1'b1;
                b_has_a = 1'b1;
                for (int i = 0; i < d; i++) begin
                    if (!(alo[i] <= blo[i] && ahi[i] >= bhi[i])) a_has_b = 1'b0;
                    if (!(blo[i] <= alo[i] && bhi[i] >= ahi[i])) b_has_a = 1'b0;
                end
                ok = a_has_b || b_has_a;
            end
        end
        if (ok && !b_empty) begin
            for (int i = 0; i < d; i++) begin
                if (a_empty) begin
                    r.box.lo[i] = p.b_lo[i];
                    r.box.hi[i] = p.b_hi[i];
                end else begin
                    r.box.lo[i] = (alo[i] < blo[i]) ? p.a_lo[i] : p.b_lo[i];
                    r.box.hi[i] = (ahi[i] > bhi[i]) ? p.a_hi[i] : p.b_hi[i];
                end
            end
        end
        r.merged = ok;
        return r;
    endfunction

    function automatic t_box_pair mk_pair(input t_coord al0, al1, al2, ah0, ah1, ah2,
                                          input t_coord bl0, bl1, bl2, bh0, bh1, bh2);
        t_box_pair p;
        p.a_lo = {al2, al1, al0};
        p.a_hi = {ah2, ah1, ah0};
        p.b_lo = {bl2, bl1, bl0};
        p.b_hi = {bh2, bh1, bh0};
        return p;
    endfunction

    function automatic t_coalesce mk_res(input logic m,
                                         input t_coord l0, l1, l2, h0, h1, h2);
        t_coalesce r;
        r.merged = m;
        r.box.lo = {l2, l1, l0};
        r.box.hi = {h2, h1, h0};
        return r;
    endfunction

    task automatic add_probe(input t_dims d, input logic known, input t_box_pair p,
                             input t_coalesce w);
        t_probe pr;
        pr.dims = d;
        pr.known = known;
        pr.pair = p;
        pr.want = w;
        probes.push_back(pr);
    endtask

    // mostly zero, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_coord pick_coord();
        case ($urandom_range(0, 7))
            0: return C_MIN + t_coord'($urandom_range(0, 3));
            1: return C_MAX - t_coord'($urandom_range(0, 3));
            2: return t_coord'($urandom);
            default: return t_coord'(int'($urandom_range(0, 40)) - 20);
        endcase
    endfunction

    function automatic t_box_pair random_pair();
        t_box_pair p;
        t_coord    ext[6];
        int        k;
        bit        grow;
        ext = '{C_MIN, C_MIN + 1, C_MAX - 1, C_MAX, 0, -1};
        for (int i = 0; i < ND; i++) begin
            p.a_lo[i] = pick_coord();
            p.a_hi[i] = p.a_lo[i] + t_coord'($urandom_range(0, 6));
        end
        p.b_lo = p.a_lo;
        p.b_hi = p.a_hi;
        k = $urandom_range(0, ND - 1);
        grow = $urandom_range(0, 1);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 8: begin
                // same box with one dimension moved: touch, overlap or gap
                p.b_lo[k] = p.a_lo[k] + t_coord'(int'($urandom_range(0, 16)) - 8);
                p.b_hi[k] = p.b_lo[k] + t_coord'(int'($urandom_range(0, 8)) - 1);
            end
            4, 5: begin
                for (int i = 0; i < ND; i++) begin
                    if (grow) begin
                        p.b_lo[i] = p.a_lo[i] - t_coord'($urandom_range(0, 2));
                        p.b_hi[i] = p.a_hi[i] + t_coord'($urandom_range(0, 2));
                    end else begin
                        p.b_lo[i] = p.a_lo[i] + t_coord'($urandom_range(0, 1));
                        p.b_hi[i] = p.a_hi[i] - t_coord'($urandom_range(0, 1));
                    end
                end
            end
            6: begin
                for (int i = 0; i < ND; i++) begin
                    p.b_lo[i] = pick_coord();
                    p.b_hi[i] = p.b_lo[i] + t_coord'($urandom_range(0, 6));
                end
            end
            7: begin
                for (int i = 0; i < ND; i++) begin
                    p.a_lo[i] = t_coord'($urandom);
                    p.a_hi[i] = t_coord'($urandom);
                    p.b_lo[i] = t_coord'($urandom);
                    p.b_hi[i] = t_coord'($urandom);
                end
            end
            default: begin
                for (int i = 0; i < ND; i++) begin
                    p.a_lo[i] = ext[$urandom_range(0, 5)];
                    p.a_hi[i] = ext[$urandom_range(0, 5)];
                    p.b_lo[i] = ext[$urandom_range(0, 5)];
                    p.b_hi[i] = ext[$urandom_range(0, 5)];
                end
            end
        endcase
        // occasionally empty one of the boxes
        if ($urandom_range(0, 9) == 0) begin
            if (grow) p.a_hi[k] = p.a_lo[k] - t_coord'($urandom_range(1, 4));
            else      p.b_hi[k] = p.b_lo[k] - t_coord'($urandom_range(1, 4));
        end
        return p;
    endfunction

    task automatic program_dims(input t_dims d);
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (union_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= d;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cur_dims = d;
    endtask

    task automatic send_pair(input t_box_pair p, input logic known, input t_coalesce want);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= p;
        do @(posedge i_clk); while (!o_s_tready);
        union_q.push_back(known ? want : predict_union(p, cur_dims));
    endtask

    task automatic check_field(input string name, input t_coord want, input t_coord got);
        if (got !== want) begin
            fault_count++;
            $error("%s: expected %0d, actual %0d", name, want, got);
        end
    endtask

    // result side backpressure
    always @(negedge i_clk) begin
        if ($urandom_range(0, 199) == 0) rx_steady = !rx_steady;
        if (stall_left > 0) begin
            i_m_tready <= 1'b0;
            stall_left--;
        end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
            i_m_tready <= 1'b0;
            stall_left = pick_gap();
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_coalesce want;
        t_box      got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata;
            if (union_q.size() == 0) begin
                fault_count++;
                $error("result with no request outstanding");
            end else begin
                want = union_q.pop_front();
                check_field("merged", t_coord'(want.merged), t_coord'(o_m_tuser[0]));
                for (int i = 0; i < ND; i++) begin
                    check_field($sformatf("out_lo%0d", i), want.box.lo[i], got.lo[i]);
                    check_field($sformatf("out_hi%0d", i), want.box.hi[i], got.hi[i]);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        t_dims dims_plan[8];
        dims_plan = '{2'd3, 2'd1, 2'd0, 2'd2, 2'd3, 2'd2, 2'd1, 2'd3};
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;

        // identical points
        add_probe(2'd3, 1'b1, mk_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                  mk_res(1'b1, 0, 0, 0, 0, 0, 0));
        // full range A holds B
        add_probe(2'd3, 1'b1,
                  mk_pair(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 0, 0, 0, 5, 5, 5),
                  mk_res(1'b1, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX));
        // B empty
        add_probe(2'd3, 1'b1, mk_pair(1, 1, 1, 2, 2, 2, 5, 0, 0, 4, 9, 9),
                  mk_res(1'b1, 1, 1, 1, 2, 2, 2));
        // A empty, B returned
        add_probe(2'd3, 1'b1, mk_pair(0, 0, C_MAX, 3, 3, C_MIN, 7, 8, 9, 10, 11, 12),
                  mk_res(1'b1, 7, 8, 9, 10, 11, 12));
        // both empty
        add_probe(2'd3, 1'b1, mk_pair(4, 0, 0, 3, 1, 1, 0, 9, 0, 1, 8, 1),
                  mk_res(1'b1, 4, 0, 0, 3, 1, 1));
        // touching, gap of one
        add_probe(2'd3, 1'b1, mk_pair(0, 0, 0, 9, 3, 3, 10, 0, 0, 20, 3, 3),
                  mk_res(1'b1, 0, 0, 0, 20, 3, 3));
        add_probe(2'd3, 1'b1, mk_pair(0, 0, 0, 9, 3, 3, 11, 0, 0, 20, 3, 3),
                  mk_res(1'b0, 0, 0, 0, 9, 3, 3));
        // B ends right below A
        add_probe(2'd3, 1'b1, mk_pair(0, 5, 0, 3, 10, 3, 0, 0, 0, 3, 4, 3),
                  mk_res(1'b1, 0, 0, 0, 3, 10, 3));
        // touch at the top of the range
        add_probe(2'd3, 1'b1,
                  mk_pair(-1, -1, C_MIN, 1, 1, C_MAX - 1, -1, -1, C_MAX, 1, 1, C_MAX),
                  mk_res(1'b1, -1, -1, C_MIN, 1, 1, C_MAX));
        // +1 must not wrap
        add_probe(2'd3, 1'b1, mk_pair(C_MAX, 0, 0, C_MAX, 0, 0, C_MIN, 0, 0, C_MIN, 0, 0),
                  mk_res(1'b0, C_MAX, 0, 0, C_MAX, 0, 0));
        add_probe(2'd3, 1'b1, mk_pair(C_MIN, 0, 0, C_MIN, 0, 0, C_MAX, 0, 0, C_MAX, 0, 0),
                  mk_res(1'b0, C_MIN, 0, 0, C_MIN, 0, 0));
        // overlap on two dims is no box
        add_probe(2'd3, 1'b1, mk_pair(0, 0, 7, 5, 5, 7, 3, 3, 7, 8, 8, 7),
                  mk_res(1'b0, 0, 0, 7, 5, 5, 7));
        // B holds A
        add_probe(2'd3, 1'b1, mk_pair(-3, -2, -1, 1, 2, 3, -4, -2, -9, 1, 5, 3),
                  mk_res(1'b1, -4, -2, -9, 1, 5, 3));
        add_probe(2'd3, 1'b1, mk_pair(-10, 2, 2, -1, 2, 2, 0, 2, 2, 7, 2, 2),
                  mk_res(1'b1, -10, 2, 2, 7, 2, 2));
        add_probe(2'd3, 1'b0,
                  mk_pair(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                          32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                          32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                          32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555), '0);
        add_probe(2'd3, 1'b0, mk_pair(-1, -1, -1, -1, -1, -1, 0, 0, 0, -1, -1, -1), '0);
        // no dimension in use
        add_probe(2'd0, 1'b1, mk_pair(5, 5, 5, 0, 0, 0, 1, 2, 3, 9, 9, 9),
                  mk_res(1'b1, 5, 5, 5, 0, 0, 0));
        add_probe(2'd0, 1'b0, mk_pair(0, 0, 0, 1, 1, 1, 50, 50, 50, 60, 60, 60), '0);
        // unused dims carry A
        add_probe(2'd1, 1'b1, mk_pair(0, 1, 2, 4, 1, 2, 5, 100, -7, 9, -100, 70),
                  mk_res(1'b1, 0, 1, 2, 9, 1, 2));
        add_probe(2'd1, 1'b1, mk_pair(0, 0, 0, 1, 0, 0, 5, 9, 0, 6, 3, 0),
                  mk_res(1'b0, 0, 0, 0, 1, 0, 0));
        add_probe(2'd2, 1'b1, mk_pair(0, 0, 9, 4, 4, 1, 0, 0, C_MIN, 4, 4, C_MAX),
                  mk_res(1'b1, 0, 0, 9, 4, 4, 1));
        add_probe(2'd2, 1'b0, mk_pair(0, 0, 0, 3, 3, 3, 2, 5, 0, 6, 9, 0), '0);
        add_probe(2'd2, 1'b0, mk_pair(0, 4, 0, 3, 9, 0, 0, 0, 5, 3, 3, 1), '0);

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (probes[n]) begin
            if (probes[n].dims != cur_dims) program_dims(probes[n].dims);
            send_pair(probes[n].pair, probes[n].known, probes[n].want);
        end

        foreach (dims_plan[ph]) begin
            program_dims(dims_plan[ph]);
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(0, 149) == 0) tx_steady = !tx_steady;
                send_pair(random_pair(), 1'b0, '0);
            end
        end

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (union_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fault_count == 0 && union_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* index_box_coalesce_test.f */
rtl/ibc_pkg.sv
rtl/ibc_core.sv
rtl/index_box_coalesce_test.sv
rtl/ibc_checker.sv
tb/index_box_coalesce_test_test.sv
